// File: rtl/dstw_pkg.sv
// Shared constants, codes and types for the DMA source chain tag walker.
package dstw_pkg;

  // Visited list depth and derived widths
  localparam int MAX_LINKS = 256;
  localparam int CNT_W     = $clog2(MAX_LINKS + 1);
  localparam int OFS_W     = 28;
  localparam int ADDR_W    = 31;
  localparam int QWC_W     = 16;
  localparam int BYTES_W   = 20;
  localparam int WIDE_W    = 32;

  // Hit reduction: cells are ORed in registered groups
  localparam int GROUP_SIZE = 16;
  localparam int NUM_GROUPS = (MAX_LINKS + GROUP_SIZE - 1) / GROUP_SIZE;

  // Memory limit (128 MiB) and tag slot size
  localparam logic [OFS_W-1:0] MEM_LIMIT = 28'h800_0000;
  localparam int               TAG_BYTES = 16;

  // Item kinds carried on s_tuser
  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_TAG     = 1'b1;

  // Tag id codes
  typedef enum logic [2:0] {
    ID_CNT  = 3'd1,
    ID_NEXT = 3'd2,
    ID_REF  = 3'd3,
    ID_REFS = 3'd4
  } tag_id_t;

  // Reported link kinds
  typedef enum logic [1:0] {
    KIND_CNT  = 2'd0,
    KIND_NEXT = 2'd1,
    KIND_REF  = 2'd2,
    KIND_REFS = 2'd3
  } link_kind_t;

  // Walker sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BOUNDS,
    ST_FINISH
  } walk_state_t;

  // Control from the walker to the visited chain
  typedef struct packed {
    logic             shift;
    logic [OFS_W-1:0] din;
    logic [OFS_W-1:0] query;
    logic [CNT_W-1:0] count;
  } chain_ctl_t;

endpackage

// File: rtl/dstw_cell.sv
// One visited-list cell: holds an offset, shifts it on, flags a match.
module dstw_cell
  import dstw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [OFS_W-1:0] din,
  input  logic [OFS_W-1:0] query,
  input  logic             live,
  output logic [OFS_W-1:0] dout,
  output logic             hit
);

  logic [OFS_W-1:0] ofs;

  // Stored offset moves one cell along on each record
  always_ff @(posedge clk) begin
    if (shift) begin
      ofs <= din;
    end
  end

  // Registered match against the current tag offset
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= live && (ofs == query);
    end
  end

  assign dout = ofs;

endmodule

// File: rtl/dstw_chain.sv
// Row of visited-list cells with a registered OR tree over their hits.
module dstw_chain
  import dstw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  chain_ctl_t ctl,
  output logic       hit
);

  logic [OFS_W-1:0]                 link [MAX_LINKS];
  logic [NUM_GROUPS*GROUP_SIZE-1:0] cell_hit;
  logic [NUM_GROUPS-1:0]            grp_hit;

  // Newest offset enters cell 0; cell i holds a live entry when i < count
  for (genvar i = 0; i < MAX_LINKS; i++) begin : g_cell
    logic [OFS_W-1:0] cell_din;
    if (i == 0) begin : g_head
      assign cell_din = ctl.din;
    end else begin : g_body
      assign cell_din = link[i-1];
    end
    dstw_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .din   (cell_din),
      .query (ctl.query),
      .live  (CNT_W'(i) < ctl.count),
      .dout  (link[i]),
      .hit   (cell_hit[i])
    );
  end

  // Padding cells of the last group never match
  for (genvar i = MAX_LINKS; i < NUM_GROUPS * GROUP_SIZE; i++) begin : g_pad
    assign cell_hit[i] = 1'b0;
  end

  // First level of the OR tree, registered per group
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_hit <= '0;
    end else begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_hit[g] <= |cell_hit[g*GROUP_SIZE +: GROUP_SIZE];
      end
    end
  end

  assign hit = |grp_hit;

endmodule

// File: rtl/dma_source_chain_tag_walker.sv
// Top level of the DMA source chain tag walker: decode, checks and sequencing.
//
//   port group     dir   role
//   s_t*           in    items: tuser = func, tdata = start ofs, raw_tag
//   m_t*           out   results: tuser = ok, kind; tdata = offsets, size
//   cfg_*          in    memory_bytes register writes
//
// Each item passes ST_IDLE, where it is accepted (the cells register their
// matches at its end), ST_DECODE (group OR registered), ST_BOUNDS and
// ST_FINISH, which loads the output register and commits state. A result
// waiting in the output register stalls only ST_FINISH of the following item.
// Synchronous reset clears the offset, the visited count and the output valid
// and sets the register to MEM_LIMIT; cell contents are left as they are.
module dma_source_chain_tag_walker
  import dstw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input: tdata [27:0] start ofs, [91:28] raw_tag; tuser [0] func
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,
  input  logic [0:0]   s_tuser,
  // output: tdata [27:0] tag_offset, [55:28] payload ofs,
  // [75:56] payload length, [103:76] next tag ofs;
  // tuser [0] ok, [2:1] link_kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,
  output logic [2:0]   m_tuser,
  // configuration write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [27:0]  cfg_data
);

  walk_state_t state, state_next;

  logic [OFS_W-1:0]  memory_bytes;
  logic [OFS_W-1:0]  current_offset;
  logic [CNT_W-1:0]  visited_count;
  logic [OFS_W-1:0]  mem;

  // Captured item
  logic              func_q;
  logic [OFS_W-1:0]  start_q;
  logic [63:0]       tag_q;

  // Decode stage results
  logic [WIDE_W-1:0]  pofs_q, nofs_q;
  logic [BYTES_W-1:0] pbytes_q;
  link_kind_t         kind_q;
  logic               pre_ok_q;
  logic               bnd_ok_q;

  // Decode logic
  logic [QWC_W-1:0]   qwc;
  logic [2:0]         id;
  logic [ADDR_W-1:0]  addr;
  logic               spr;
  logic [BYTES_W-1:0] pbytes;
  logic [OFS_W:0]     cur16;
  logic [WIDE_W-1:0]  pofs, nofs;
  link_kind_t         kind;
  logic               rule_ok, slot_ok;
  logic [WIDE_W:0]    pend;

  logic       load_out, accept, hit;
  chain_ctl_t ctl;

  // Output registers
  logic             ok_o;
  logic [OFS_W-1:0] tag_ofs_o, pofs_o, nofs_o;
  logic [BYTES_W-1:0] pbytes_o;
  link_kind_t       kind_o;

  assign cfg_ready = 1'b1;
  assign mem = (memory_bytes > MEM_LIMIT) ? MEM_LIMIT : memory_bytes;

  // Tag field decode and per-kind rules
  always_comb begin
    qwc    = tag_q[15:0];
    id     = tag_q[30:28];
    addr   = tag_q[62:32];
    spr    = tag_q[63];
    pbytes = {qwc, 4'b0000};
    cur16  = {1'b0, current_offset} + (OFS_W+1)'(TAG_BYTES);
    pofs    = '0;
    nofs    = '0;
    kind    = KIND_CNT;
    rule_ok = 1'b0;
    case (id)
      ID_CNT: begin
        rule_ok = (addr == '0);
        pofs    = WIDE_W'(cur16);
        nofs    = WIDE_W'(cur16) + WIDE_W'(pbytes);
        kind    = KIND_CNT;
      end
      ID_NEXT: begin
        rule_ok = (addr != '0);
        pofs    = WIDE_W'(cur16);
        nofs    = WIDE_W'(addr);
        kind    = KIND_NEXT;
      end
      ID_REF, ID_REFS: begin
        rule_ok = !((qwc != '0) && (addr == '0));
        pofs    = WIDE_W'(addr);
        nofs    = WIDE_W'(cur16);
        kind    = (id == ID_REF) ? KIND_REF : KIND_REFS;
      end
      default: begin
        rule_ok = 1'b0;
      end
    endcase
    slot_ok = (visited_count < CNT_W'(MAX_LINKS)) &&
              (cur16 <= (OFS_W+1)'(mem)) &&
              (current_offset[3:0] == 4'h0);
    pend = {1'b0, pofs_q} + (WIDE_W+1)'(pbytes_q);
  end

  // Item capture, decode and bounds pipeline registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_q  <= s_tuser[0];
      start_q <= s_tdata[27:0];
      tag_q   <= s_tdata[91:28];
    end
    if (state == ST_DECODE) begin
      pofs_q   <= pofs;
      nofs_q   <= nofs;
      pbytes_q <= pbytes;
      kind_q   <= kind;
      pre_ok_q <= slot_ok && !spr && rule_ok;
    end
    if (state == ST_BOUNDS) begin
      bnd_ok_q <= (pofs_q[3:0] == 4'h0) && (pend <= (WIDE_W+1)'(mem)) &&
                  (nofs_q[3:0] == 4'h0) && (nofs_q <= WIDE_W'(mem));
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_BOUNDS;
      end
      ST_BOUNDS: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept = pre_ok_q && bnd_ok_q && !hit;

  // Visited chain
  always_comb begin
    ctl.shift = load_out && (func_q == FUNC_TAG) && accept;
    ctl.din   = current_offset;
    ctl.query = current_offset;
    ctl.count = visited_count;
  end

  dstw_chain u_chain (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .hit (hit)
  );

  // Walker state and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_bytes   <= MEM_LIMIT;
      current_offset <= '0;
      visited_count  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        memory_bytes <= cfg_data;
      end
      if (load_out) begin
        if (func_q == FUNC_RESTART) begin
          current_offset <= start_q;
          visited_count  <= '0;
        end else if (accept) begin
          current_offset <= nofs_q[OFS_W-1:0];
          visited_count  <= visited_count + CNT_W'(1);
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (func_q == FUNC_RESTART) begin
        ok_o      <= 1'b1;
        tag_ofs_o <= start_q;
        pofs_o    <= '0;
        pbytes_o  <= '0;
        nofs_o    <= start_q;
        kind_o    <= KIND_CNT;
      end else if (accept) begin
        ok_o      <= 1'b1;
        tag_ofs_o <= current_offset;
        pofs_o    <= pofs_q[OFS_W-1:0];
        pbytes_o  <= pbytes_q;
        nofs_o    <= nofs_q[OFS_W-1:0];
        kind_o    <= kind_q;
      end else begin
        ok_o      <= 1'b0;
        tag_ofs_o <= current_offset;
        pofs_o    <= '0;
        pbytes_o  <= '0;
        nofs_o    <= '0;
        kind_o    <= KIND_CNT;
      end
    end
  end

  assign m_tuser = {kind_o, ok_o};
  assign m_tdata = {nofs_o, pbytes_o, pofs_o, tag_ofs_o};

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the DMA source chain tag walker.
module tb_top;
  import dstw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 850;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;
  // ids with no meaning, all of which must be refused
  localparam logic [2:0] UNLISTED_IDS [4] = '{3'd0, 3'd5, 3'd6, 3'd7};

  // One walker outcome, field for field
  typedef struct packed {
    logic               ok;
    logic [OFS_W-1:0]   tag_ofs;
    logic [OFS_W-1:0]   pay_ofs;
    logic [BYTES_W-1:0] pay_bytes;
    logic [OFS_W-1:0]   next_ofs;
    link_kind_t         kind;
  } walk_result_t;

  typedef struct {
    logic         func;
    logic [27:0]  start;
    logic [63:0]  tag;
    bit           typed;
    walk_result_t want;
  } dir_row_t;

  logic         clk;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata   = '0;   // [27:0] start ofs, [91:28] raw_tag
  logic [0:0]   s_tuser   = '0;   // [0] func
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [103:0] m_tdata;          // [27:0] tag_offset .. [103:76] next tag ofs
  logic [2:0]   m_tuser;          // [0] ok, [2:1] link_kind
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [27:0]  cfg_data  = '0;

  // Walker state as the testbench sees it
  logic [OFS_W-1:0] chain_pos;
  logic [OFS_W-1:0] visited_ofs [MAX_LINKS];
  int               visited_num;
  logic [OFS_W-1:0] mem_reg;

  walk_result_t pending_results [$];
  dir_row_t     dir_rows [$];
  bit           calm;
  int           fail_count, items_sent, results_seen, cfg_writes;
  int           restarts, tags_taken, tags_refused;

  dma_source_chain_tag_walker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic walk_result_t outcome(logic ok, logic [27:0] tofs, logic [27:0] pofs,
                                           logic [19:0] pbytes, logic [27:0] nofs,
                                           link_kind_t kind);
    walk_result_t r;
    r.ok        = ok;
    r.tag_ofs   = tofs;
    r.pay_ofs   = pofs;
    r.pay_bytes = pbytes;
    r.next_ofs  = nofs;
    r.kind      = kind;
    return r;
  endfunction

  function automatic walk_result_t refused(logic [27:0] tofs);
    return outcome(1'b0, tofs, '0, '0, '0, KIND_CNT);
  endfunction

  // spr, addr, id and qwc; junk fills bit 31 and bits 27:16
  function automatic logic [63:0] tag_word(logic spr, logic [30:0] addr, logic [2:0] id,
                                           logic [15:0] qwc, logic [12:0] junk);
    return {spr, addr, junk[12], id, junk[11:0], qwc};
  endfunction

  function automatic bit fits(longint unsigned ofs, longint unsigned len,
                              longint unsigned mem_size);
    return ofs <= mem_size && len <= mem_size - ofs;
  endfunction

  function automatic longint unsigned mem_now();
    return (mem_reg > MEM_LIMIT) ? longint'(MEM_LIMIT) : longint'(mem_reg);
  endfunction

  // Walker prediction: a restart moves chain_pos to start; a tag is checked at chain_pos and advances it on success
  function automatic walk_result_t walk_step(logic func, logic [27:0] start,
                                             logic [63:0] tag);
    walk_result_t    r;
    longint unsigned mem, cur, qwc, addr, pbytes, pofs, nofs;
    link_kind_t      kind;
    r = refused(chain_pos);
    if (func == FUNC_RESTART) begin
      chain_pos   = start;
      visited_num = 0;
      return outcome(1'b1, start, '0, '0, start, KIND_CNT);
    end
    mem = mem_now();
    cur = chain_pos;
    if (visited_num >= MAX_LINKS || !fits(cur, TAG_BYTES, mem) || cur % 16 != 0)
      return r;
    for (int i = 0; i < visited_num; i++)
      if (visited_ofs[i] == chain_pos) return r;
    if (tag[63]) return r;
    qwc    = tag[15:0];
    addr   = tag[62:32];
    pbytes = qwc * 16;
    case (tag[30:28])
      ID_CNT: begin
        if (addr != 0) return r;
        pofs = cur + TAG_BYTES;
        nofs = pofs + pbytes;
        kind = KIND_CNT;
      end
      ID_NEXT: begin
        if (addr == 0) return r;
        pofs = cur + TAG_BYTES;
        nofs = addr;
        kind = KIND_NEXT;
      end
      ID_REF, ID_REFS: begin
        if (qwc != 0 && addr == 0) return r;
        pofs = addr;
        nofs = cur + TAG_BYTES;
        kind = (tag[30:28] == ID_REF) ? KIND_REF : KIND_REFS;
      end
      default: return r;
    endcase
    if (pofs % 16 != 0 || !fits(pofs, pbytes, mem) || nofs % 16 != 0 || !fits(nofs, 0, mem))
      return r;
    visited_ofs[visited_num] = chain_pos;
    visited_num++;
    chain_pos = nofs[27:0];
    return outcome(1'b1, 28'(cur), 28'(pofs), 20'(pbytes), 28'(nofs), kind);
  endfunction

  // A tag built to pass the field and bounds checks at the current position, random content
  function automatic logic [63:0] chain_tag();
    longint unsigned mem, cur, span, addr, qmax;
    logic [15:0]     qwc;
    logic [2:0]      id;
    mem = mem_now();
    cur = chain_pos;
    if (cur + TAG_BYTES > mem || cur % 16 != 0)
      return {$urandom, $urandom};
    // a narrow window makes jumps back onto visited tags likely
    span = ($urandom_range(0, 1) == 0 && mem > 'h2000) ? 'h2000 : mem;
    case ($urandom_range(0, 3))
      0: begin
        id   = ID_CNT;
        addr = 0;
        qmax = (mem - cur - TAG_BYTES) / 16;
      end
      1: begin
        id   = ID_NEXT;
        addr = 16 * longint'($urandom_range(1, 32'(span / 16)));
        qmax = (mem - cur - TAG_BYTES) / 16;
      end
      default: begin
        id   = ($urandom_range(0, 1) == 0) ? ID_REF : ID_REFS;
        addr = 16 * longint'($urandom_range(0, 32'(span / 16)));
        qmax = (addr == 0) ? 0 : (mem - addr) / 16;
      end
    endcase
    if (qmax > 'hFFFF) qmax = 'hFFFF;
    qwc = ($urandom_range(0, 7) == 0) ? 16'(qmax)
                                      : 16'($urandom_range(0, (qmax < 64) ? 32'(qmax) : 64));
    return tag_word(1'b0, addr[30:0], id, qwc, 13'($urandom));
  endfunction

  function automatic logic [27:0] pick_start();
    longint unsigned mem;
    mem = mem_now();
    if (mem < TAG_BYTES || $urandom_range(0, 19) == 0) return 28'($urandom);
    if (mem > 'h2000 && $urandom_range(0, 1) == 0) mem = 'h2000;
    return 28'(16 * longint'($urandom_range(0, 32'((mem - TAG_BYTES) / 16))));
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void log_failure(string what, walk_result_t want, walk_result_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s: exp ok=%0d tag=%h pay=%h bytes=%h next=%h kind=%0d",
               $time, what, want.ok, want.tag_ofs, want.pay_ofs, want.pay_bytes,
               want.next_ofs, want.kind);
      $display("%0t %s: got ok=%0d tag=%h pay=%h bytes=%h next=%h kind=%0d",
               $time, what, got.ok, got.tag_ofs, got.pay_ofs, got.pay_bytes,
               got.next_ofs, got.kind);
    end
  endfunction

  function automatic void add_row(logic func, logic [27:0] start, logic [63:0] tag,
                                  bit typed, walk_result_t want);
    dir_row_t row;
    row.func  = func;
    row.start = start;
    row.tag   = tag;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // One input transfer; the outcome is queued once it has been taken
  task automatic send_item(logic func, logic [27:0] start, logic [63:0] tag,
                           bit typed, walk_result_t want);
    walk_result_t pred;
    int           gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0, tag, start};
    do @(posedge clk); while (!s_tready);
    pred = walk_step(func, start, tag);
    pending_results.insert(pending_results.size(), typed ? want : pred);
    items_sent++;
    if (func == FUNC_RESTART) restarts++;
    else if (pred.ok) tags_taken++;
    else tags_refused++;
  endtask

  // Register write once the walker has drained
  task automatic set_memory(logic [27:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mem_reg = value;
    cfg_writes++;
  endtask

  // Restart, then a run of tags that mostly follow the chain
  task automatic run_chain(int tags);
    logic [63:0] tag;
    int          roll;
    calm = ($urandom_range(0, 3) == 0);
    send_item(FUNC_RESTART, pick_start(), {$urandom, $urandom}, 1'b0, '0);
    for (int n = 0; n < tags; n++) begin
      roll = $urandom_range(0, 99);
      tag  = chain_tag();
      if (roll < 10) tag[$urandom_range(0, 63)] ^= 1'b1;
      else if (roll < 15) tag = {$urandom, $urandom};
      if (roll >= 97)
        send_item(FUNC_RESTART, roll[0] ? pick_start() : 28'($urandom), tag, 1'b0, '0);
      else
        send_item(FUNC_TAG, 28'($urandom), tag, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, with calm stretches
  always @(posedge clk) begin : result_stall
    int hold;
    if (rst) begin
      m_tready <= 1'b0;
      hold = 0;
    end else if (hold != 0) begin
      m_tready <= 1'b0;
      hold--;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
    end
  end

  // Result check against the oldest outcome waiting
  always @(posedge clk) begin : result_check
    walk_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.ok        = m_tuser[0];
      got.tag_ofs   = m_tdata[27:0];
      got.pay_ofs   = m_tdata[55:28];
      got.pay_bytes = m_tdata[75:56];
      got.next_ofs  = m_tdata[103:76];
      got.kind      = link_kind_t'(m_tuser[2:1]);
      results_seen++;
      if (pending_results.size() == 0) begin
        log_failure("unexpected result", got, got);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.tag_ofs !== want.tag_ofs ||
            got.pay_ofs !== want.pay_ofs || got.pay_bytes !== want.pay_bytes ||
            got.next_ofs !== want.next_ofs || got.kind !== want.kind)
          log_failure("mismatch", want, got);
      end
    end
  end

  // Give up when nothing has moved for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main
    chain_pos   = '0;
    visited_num = 0;
    mem_reg     = MEM_LIMIT;
    calm        = 1'b0;

    // Directed walk from reset, 128 MiB memory
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_CNT, '0, '0), 1'b1,
            outcome(1'b1, 28'd0, 28'd16, 20'd0, 28'd16, KIND_CNT));
    add_row(FUNC_TAG, 28'hFFFFFFF, tag_word(1'b0, 31'd1, ID_CNT, '0, '0), 1'b1,
            refused(28'd16));
    add_row(FUNC_TAG, 28'd0, tag_word(1'b1, '0, ID_CNT, '0, '0), 1'b1, refused(28'd16));
    foreach (UNLISTED_IDS[i])
      add_row(FUNC_TAG, 28'd0, tag_word(1'b0, 31'h100, UNLISTED_IDS[i], 16'd1, '0), 1'b1,
              refused(28'd16));
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_NEXT, 16'd2, '0), 1'b1, refused(28'd16));
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, 31'h100, ID_NEXT, 16'd2, '0), 1'b0, '0);
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_REF, 16'd1, '0), 1'b1, refused(28'h100));
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_REF, '0, '0), 1'b0, '0);
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, 31'h200, ID_REFS, 16'd3, '1), 1'b0, '0);
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, 31'h10, ID_NEXT, '0, '0), 1'b0, '0);
    // jump back to offset 0x10, where the earlier tags were refused
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_CNT, '0, '0), 1'b1, refused(28'h10));
    add_row(FUNC_RESTART, 28'hFFFFFFF, '1, 1'b1,
            outcome(1'b1, 28'hFFFFFFF, '0, '0, 28'hFFFFFFF, KIND_CNT));
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_CNT, '0, '0), 1'b1, refused(28'hFFFFFFF));
    add_row(FUNC_RESTART, MEM_LIMIT - 28'd16, '0, 1'b1,
            outcome(1'b1, MEM_LIMIT - 28'd16, '0, '0, MEM_LIMIT - 28'd16, KIND_CNT));
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_CNT, 16'd1, '0), 1'b1,
            refused(MEM_LIMIT - 28'd16));
    // next offset landing exactly on the memory end is fine, the slot there is not
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_CNT, '0, '0), 1'b0, '0);
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_CNT, '0, '0), 1'b1, refused(MEM_LIMIT));
    add_row(FUNC_RESTART, 28'd8, '0, 1'b0, '0);
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, '0, ID_CNT, '0, '0), 1'b1, refused(28'd8));
    add_row(FUNC_RESTART, 28'd0, '0, 1'b0, '0);
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, 31'h7FFFFFFF, ID_NEXT, 16'hFFFF, '1), 1'b1,
            refused(28'd0));
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, 31'h10, ID_REF, 16'hFFFF, '0), 1'b0, '0);
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, 31'h7FFFFF0, ID_REFS, 16'd1, '0), 1'b0, '0);
    add_row(FUNC_TAG, 28'd0, tag_word(1'b0, 31'h7FFFFF8, ID_NEXT, '0, '0), 1'b1,
            refused(28'h20));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].func, dir_rows[i].start, dir_rows[i].tag, dir_rows[i].typed,
                dir_rows[i].want);

    // No memory at all, then a single tag slot
    set_memory(28'd0);
    run_chain(8);
    run_chain(8);
    set_memory(28'd16);
    run_chain(4);
    run_chain(4);

    // Oversized value clamps; fill the visited list until it refuses
    set_memory(28'hFFFFFFF);
    send_item(FUNC_RESTART, '0, '0, 1'b0, '0);
    for (int n = 0; n <= MAX_LINKS + 1; n++)
      send_item(FUNC_TAG, '0, tag_word(1'b0, '0, ID_CNT, '0, 13'($urandom)), n >= MAX_LINKS,
                refused(28'(MAX_LINKS * TAG_BYTES)));

    // Random chains under changing memory sizes
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0: set_memory(28'($urandom));
          1: set_memory(28'(16 * $urandom_range(1, 512)));
          2: set_memory(MEM_LIMIT);
          default: set_memory(28'(16 * $urandom_range(1, 32'h800000)));
        endcase
      end
      run_chain($urandom_range(1, 24));
    end
    set_memory(MEM_LIMIT);
    run_chain(10);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Walked %0d items: %0d restarts, %0d tags taken, %0d refused; %0d results seen.",
             items_sent, restarts, tags_taken, tags_refused, results_seen);
    $display("Memory size set %0d times incl. zero, one slot, clamp and a full visited list.",
             cfg_writes);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
rtl/dstw_pkg.sv
rtl/dstw_cell.sv
rtl/dstw_chain.sv
rtl/dma_source_chain_tag_walker.sv
tb/sv/tb_top.sv
